@@ design/ivalu_pkg.sv @@
`default_nettype none
package ivalu_pkg;

   localparam int LANES      = 4;
   localparam int DATA_W     = 32;
   localparam int SCALAR_W   = 64;
   localparam int DIV_STAGES = DATA_W;
   localparam int PIPE_DEPTH = DIV_STAGES + 1;

   typedef logic [3:0] opcode_type;

   localparam opcode_type OP_ADD     = 4'd0;
   localparam opcode_type OP_SUB     = 4'd1;
   localparam opcode_type OP_MUL     = 4'd2;
   localparam opcode_type OP_DIV     = 4'd3;
   localparam opcode_type OP_SCALE   = 4'd4;
   localparam opcode_type OP_SPLAT   = 4'd5;
   localparam opcode_type OP_SUM     = 4'd6;
   localparam opcode_type OP_PRODUCT = 4'd7;
   localparam opcode_type OP_MIN     = 4'd8;
   localparam opcode_type OP_MAX     = 4'd9;
   localparam opcode_type OP_GET     = 4'd10;
   localparam opcode_type OP_SET     = 4'd11;

   typedef struct packed {
      opcode_type                 opcode;
      logic [1:0]                 lane_index;
      logic signed [DATA_W-1:0]   scalar_operand;
   } cmd_type;

endpackage
`default_nettype wire

@@ design/ivalu_if.sv @@
`default_nettype none
interface ivalu_req_if;
   logic                                   valid;
   logic                                   ready;
   ivalu_pkg::opcode_type                  opcode;
   logic signed [ivalu_pkg::DATA_W-1:0]    a_lane0;
   logic signed [ivalu_pkg::DATA_W-1:0]    a_lane1;
   logic signed [ivalu_pkg::DATA_W-1:0]    a_lane2;
   logic signed [ivalu_pkg::DATA_W-1:0]    a_lane3;
   logic signed [ivalu_pkg::DATA_W-1:0]    b_lane0;
   logic signed [ivalu_pkg::DATA_W-1:0]    b_lane1;
   logic signed [ivalu_pkg::DATA_W-1:0]    b_lane2;
   logic signed [ivalu_pkg::DATA_W-1:0]    b_lane3;
   logic signed [ivalu_pkg::DATA_W-1:0]    scalar_operand;
   logic [1:0]                             lane_index;

   modport source (output valid, opcode, a_lane0, a_lane1, a_lane2, a_lane3,
                   b_lane0, b_lane1, b_lane2, b_lane3, scalar_operand, lane_index,
                   input ready);
   modport sink   (input valid, opcode, a_lane0, a_lane1, a_lane2, a_lane3,
                   b_lane0, b_lane1, b_lane2, b_lane3, scalar_operand, lane_index,
                   output ready);
endinterface

interface ivalu_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ivalu_pkg::DATA_W-1:0]    r_lane0;
   logic signed [ivalu_pkg::DATA_W-1:0]    r_lane1;
   logic signed [ivalu_pkg::DATA_W-1:0]    r_lane2;
   logic signed [ivalu_pkg::DATA_W-1:0]    r_lane3;
   logic signed [ivalu_pkg::SCALAR_W-1:0]  scalar_result;

   modport source (output valid, r_lane0, r_lane1, r_lane2, r_lane3, scalar_result,
                   input ready);
   modport sink   (input valid, r_lane0, r_lane1, r_lane2, r_lane3, scalar_result,
                   output ready);
endinterface
`default_nettype wire

@@ design/int32_vector_alu.sv @@
`default_nettype none
// Four-lane signed 32-bit vector ALU. One transaction is accepted every cycle while the
// result side takes results; each result passes through 33 pipeline stages plus the output
// register, a depth set by the per-lane radix-2 divider, which retires one quotient bit
// per stage. All operations pass through those same stages, so results leave in order.
// Back-pressure on the result side stalls the whole pipeline.
module int32_vector_alu (
   input  wire logic  clock,
   input  wire logic  reset,
   ivalu_req_if.sink  req,
   ivalu_rsp_if.source rsp
);

   localparam int W = ivalu_pkg::DATA_W;
   localparam int L = ivalu_pkg::LANES;
   localparam int D = ivalu_pkg::PIPE_DEPTH;

   logic                      adv;
   logic [D-1:0]              valid_ff;
   logic                      out_valid_ff;
   ivalu_pkg::cmd_type        cmd;
   logic signed [W-1:0]       a_vec [L];
   logic signed [W-1:0]       b_vec [L];
   logic signed [W-1:0]       r_vec [L];
   logic signed [W-1:0]       r_ff  [L];
   logic signed [ivalu_pkg::SCALAR_W-1:0] scalar;
   logic signed [ivalu_pkg::SCALAR_W-1:0] scalar_ff;

   assign adv       = !out_valid_ff || rsp.ready;
   assign req.ready = adv;

   assign cmd.opcode         = req.opcode;
   assign cmd.lane_index     = req.lane_index;
   assign cmd.scalar_operand = req.scalar_operand;

   assign a_vec[0] = req.a_lane0;
   assign a_vec[1] = req.a_lane1;
   assign a_vec[2] = req.a_lane2;
   assign a_vec[3] = req.a_lane3;
   assign b_vec[0] = req.b_lane0;
   assign b_vec[1] = req.b_lane1;
   assign b_vec[2] = req.b_lane2;
   assign b_vec[3] = req.b_lane3;

   for (genvar i = 0; i < L; i++) begin : g_lane
      ivalu_lane u_lane (
         .clock   (clock),
         .adv     (adv),
         .lane_id (2'(i)),
         .cmd     (cmd),
         .a       (a_vec[i]),
         .b       (b_vec[i]),
         .result  (r_vec[i])
      );
   end

   ivalu_merge u_merge (
      .clock  (clock),
      .adv    (adv),
      .cmd    (cmd),
      .a      (a_vec),
      .scalar (scalar)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= {valid_ff[D-2:0], req.valid};
         out_valid_ff <= valid_ff[D-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < L; i++) begin
            r_ff[i] <= r_vec[i];
         end
         scalar_ff <= scalar;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.r_lane0       = r_ff[0];
   assign rsp.r_lane1       = r_ff[1];
   assign rsp.r_lane2       = r_ff[2];
   assign rsp.r_lane3       = r_ff[3];
   assign rsp.scalar_result = scalar_ff;

   a_scalar_excludes_vector: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.scalar_result != '0 |->
         rsp.r_lane0 == '0 && rsp.r_lane1 == '0 && rsp.r_lane2 == '0 && rsp.r_lane3 == '0)
      else $error("vector and scalar result both non-zero");

   a_result_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(valid_ff[D-1]))
      else $error("result appeared without a transaction in the last stage");

   a_entry_from_accept: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && $past(adv) |-> $past(req.valid))
      else $error("pipeline entry without an accepted transaction");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !$past(adv) && !$past(reset) |-> $stable(valid_ff))
      else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

@@ design/ivalu_lane.sv @@
`default_nettype none
module ivalu_lane (
   input  wire logic                               clock,
   input  wire logic                               adv,
   input  wire logic [1:0]                         lane_id,
   input  wire ivalu_pkg::cmd_type                 cmd,
   input  wire logic signed [ivalu_pkg::DATA_W-1:0] a,
   input  wire logic signed [ivalu_pkg::DATA_W-1:0] b,
   output logic signed [ivalu_pkg::DATA_W-1:0]      result
);

   localparam int W = ivalu_pkg::DATA_W;
   localparam int N = ivalu_pkg::DIV_STAGES;

   logic [W-1:0] mul_op;
   logic [W-1:0] prod;
   logic [W-1:0] early_in;

   logic [W-1:0] early_ff [0:N];
   logic         is_div_ff[0:N];
   logic         neg_ff   [0:N];
   logic         zero_ff  [0:N];
   logic [W-1:0] den_ff   [0:N];
   logic [W-1:0] rem_ff   [0:N];
   logic [W-1:0] nq_ff    [0:N];

   logic [W-1:0] rem_in   [1:N];
   logic [W-1:0] nq_in    [1:N];
   logic [W:0]   cat      [1:N];
   logic         ge       [1:N];
   logic [W-1:0] quot;

   assign mul_op = (cmd.opcode == ivalu_pkg::OP_SCALE) ? cmd.scalar_operand : b;
   assign prod   = a * mul_op;

   always_comb begin
      early_in = '0;
      unique case (cmd.opcode)
         ivalu_pkg::OP_ADD:   early_in = a + b;
         ivalu_pkg::OP_SUB:   early_in = a - b;
         ivalu_pkg::OP_MUL:   early_in = prod;
         ivalu_pkg::OP_SCALE: early_in = prod;
         ivalu_pkg::OP_SPLAT: early_in = cmd.scalar_operand;
         ivalu_pkg::OP_SET:   early_in = (cmd.lane_index == lane_id) ? cmd.scalar_operand : a;
         default:             early_in = '0;
      endcase
   end

   // one quotient bit per stage, restoring
   always_comb begin
      for (int k = 1; k <= N; k++) begin
         cat[k]    = {rem_ff[k-1], nq_ff[k-1][W-1]};
         ge[k]     = cat[k] >= {1'b0, den_ff[k-1]};
         rem_in[k] = ge[k] ? W'(cat[k] - {1'b0, den_ff[k-1]}) : cat[k][W-1:0];
         nq_in[k]  = {nq_ff[k-1][W-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         early_ff[0]  <= early_in;
         is_div_ff[0] <= cmd.opcode == ivalu_pkg::OP_DIV;
         neg_ff[0]    <= a[W-1] ^ b[W-1];
         zero_ff[0]   <= b == '0;
         den_ff[0]    <= b[W-1] ? -b : b;
         rem_ff[0]    <= '0;
         nq_ff[0]     <= a[W-1] ? -a : a;
         for (int k = 1; k <= N; k++) begin
            early_ff[k]  <= early_ff[k-1];
            is_div_ff[k] <= is_div_ff[k-1];
            neg_ff[k]    <= neg_ff[k-1];
            zero_ff[k]   <= zero_ff[k-1];
            den_ff[k]    <= den_ff[k-1];
            rem_ff[k]    <= rem_in[k];
            nq_ff[k]     <= nq_in[k];
         end
      end
   end

   assign quot   = neg_ff[N] ? -nq_ff[N] : nq_ff[N];
   assign result = !is_div_ff[N] ? early_ff[N] : (zero_ff[N] ? '1 : quot);

endmodule
`default_nettype wire

@@ design/ivalu_merge.sv @@
`default_nettype none
module ivalu_merge (
   input  wire logic                                clock,
   input  wire logic                                adv,
   input  wire ivalu_pkg::cmd_type                  cmd,
   input  wire logic signed [ivalu_pkg::DATA_W-1:0] a [ivalu_pkg::LANES],
   output logic signed [ivalu_pkg::SCALAR_W-1:0]    scalar
);

   localparam int W = ivalu_pkg::DATA_W;
   localparam int S = ivalu_pkg::SCALAR_W;
   localparam int D = ivalu_pkg::PIPE_DEPTH;

   logic                  is_min;
   logic signed [W:0]     s01_in, s23_in;
   logic signed [S-1:0]   p01_in, p23_in;
   logic signed [W-1:0]   m01_in, m23_in;

   ivalu_pkg::opcode_type op0_ff, op1_ff;
   logic signed [W:0]     s01_ff, s23_ff;
   logic signed [S-1:0]   p01_ff, p23_ff;
   logic signed [W-1:0]   m01_ff, m23_ff, get0_ff;

   logic signed [S-1:0]   sum_ff;
   logic [S-1:0]          ll_ff;
   logic [W-1:0]          cross_ff;
   logic signed [W-1:0]   mm_ff, get1_ff;
   logic [S-1:0]          cross_a, cross_b;
   logic signed [W-1:0]   mm_in;

   logic signed [S-1:0]   sres_in;
   logic signed [S-1:0]   sres_ff [2:D-1];

   assign is_min = cmd.opcode == ivalu_pkg::OP_MIN;
   assign s01_in = {a[0][W-1], a[0]} + {a[1][W-1], a[1]};
   assign s23_in = {a[2][W-1], a[2]} + {a[3][W-1], a[3]};
   assign p01_in = a[0] * a[1];
   assign p23_in = a[2] * a[3];
   assign m01_in = is_min ? ((a[1] < a[0]) ? a[1] : a[0]) : ((a[1] > a[0]) ? a[1] : a[0]);
   assign m23_in = is_min ? ((a[3] < a[2]) ? a[3] : a[2]) : ((a[3] > a[2]) ? a[3] : a[2]);

   assign mm_in   = (op0_ff == ivalu_pkg::OP_MIN) ? ((m23_ff < m01_ff) ? m23_ff : m01_ff)
                                                  : ((m23_ff > m01_ff) ? m23_ff : m01_ff);
   assign cross_a = p01_ff[W-1:0] * p23_ff[S-1:W];
   assign cross_b = p01_ff[S-1:W] * p23_ff[W-1:0];

   always_comb begin
      sres_in = '0;
      unique case (op1_ff)
         ivalu_pkg::OP_SUM:     sres_in = sum_ff;
         ivalu_pkg::OP_PRODUCT: sres_in = ll_ff + {cross_ff, {W{1'b0}}};
         ivalu_pkg::OP_MIN:     sres_in = S'(mm_ff);
         ivalu_pkg::OP_MAX:     sres_in = S'(mm_ff);
         ivalu_pkg::OP_GET:     sres_in = S'(get1_ff);
         default:               sres_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op0_ff   <= cmd.opcode;
         s01_ff   <= s01_in;
         s23_ff   <= s23_in;
         p01_ff   <= p01_in;
         p23_ff   <= p23_in;
         m01_ff   <= m01_in;
         m23_ff   <= m23_in;
         get0_ff  <= a[cmd.lane_index];

         op1_ff   <= op0_ff;
         sum_ff   <= S'(s01_ff) + S'(s23_ff);
         ll_ff    <= p01_ff[W-1:0] * p23_ff[W-1:0];
         cross_ff <= cross_a[W-1:0] + cross_b[W-1:0];
         mm_ff    <= mm_in;
         get1_ff  <= get0_ff;

         sres_ff[2] <= sres_in;
         for (int k = 3; k < D; k++) begin
            sres_ff[k] <= sres_ff[k-1];
         end
      end
   end

   assign scalar = sres_ff[D-1];

endmodule
`default_nettype wire

@@ tb/ivalu_tb_if.sv @@
`timescale 1ns / 1ps
// Interfaces are supplied by the design; nothing further is needed here.
package ivalu_tb_pkg;
   import ivalu_pkg::*;

   typedef struct {
      opcode_type       opcode;
      logic signed [31:0] a [4];
      logic signed [31:0] b [4];
      logic signed [31:0] scalar_operand;
      logic [1:0]       lane_index;
   } alu_txn_type;

   typedef struct {
      logic signed [31:0] r [4];
      logic signed [63:0] scalar_result;
   } alu_res_type;

   class alu_scoreboard;
      alu_res_type pending_results[$];
      int          mismatches;

      function alu_res_type compute(alu_txn_type t);
         alu_res_type        e;
         logic signed [63:0] acc;
         logic signed [63:0] m;
         logic signed [63:0] v;
         for (int i = 0; i < 4; i++) e.r[i] = '0;
         e.scalar_result = '0;
         case (t.opcode)
            OP_ADD: for (int i = 0; i < 4; i++) e.r[i] = t.a[i] + t.b[i];
            OP_SUB: for (int i = 0; i < 4; i++) e.r[i] = t.a[i] - t.b[i];
            OP_MUL: for (int i = 0; i < 4; i++) e.r[i] = t.a[i] * t.b[i];
            OP_DIV: begin
               for (int i = 0; i < 4; i++) begin
                  if (t.b[i] == 0) e.r[i] = -32'sd1;
                  else begin
                     acc = 64'(t.a[i]) / 64'(t.b[i]);
                     e.r[i] = acc[31:0];
                  end
               end
            end
            OP_SCALE: for (int i = 0; i < 4; i++) e.r[i] = t.a[i] * t.scalar_operand;
            OP_SPLAT: for (int i = 0; i < 4; i++) e.r[i] = t.scalar_operand;
            OP_SUM: begin
               acc = 0;
               for (int i = 0; i < 4; i++) acc += 64'(t.a[i]);
               e.scalar_result = acc;
            end
            OP_PRODUCT: begin
               acc = 1;
               for (int i = 0; i < 4; i++) acc *= 64'(t.a[i]);
               e.scalar_result = acc;
            end
            OP_MIN, OP_MAX: begin
               m = 64'(t.a[0]);
               for (int i = 1; i < 4; i++) begin
                  v = 64'(t.a[i]);
                  if (t.opcode == OP_MIN ? (v < m) : (v > m)) m = v;
               end
               e.scalar_result = m;
            end
            OP_GET: e.scalar_result = 64'(t.a[t.lane_index]);
            OP_SET: begin
               for (int i = 0; i < 4; i++) e.r[i] = t.a[i];
               e.r[t.lane_index] = t.scalar_operand;
            end
            default: ;
         endcase
         return e;
      endfunction

      function void note_request(alu_txn_type t);
         pending_results.push_back(compute(t));
      endfunction

      function void check_result(alu_res_type got);
         alu_res_type e;
         bit          bad;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction");
            return;
         end
         e = pending_results.pop_front();
         bad = (got.scalar_result !== e.scalar_result);
         for (int i = 0; i < 4; i++) if (got.r[i] !== e.r[i]) bad = 1;
         if (bad) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp %h %h %h %h %h got %h %h %h %h %h",
                        e.r[0], e.r[1], e.r[2], e.r[3], e.scalar_result,
                        got.r[0], got.r[1], got.r[2], got.r[3], got.scalar_result);
         end
      endfunction
   endclass
endpackage

@@ tb/tb_int32_vector_alu.sv @@
`timescale 1ns / 1ps
module tb_int32_vector_alu;
   import ivalu_pkg::*;
   import ivalu_tb_pkg::*;

   localparam int LIMIT = 400000;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   bit   sender_done;
   bit   hold_rsp;
   alu_scoreboard sb;

   ivalu_req_if req ();
   ivalu_rsp_if rsp ();

   int32_vector_alu u_top (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0;
         4: return 32'(int'($urandom_range(0, 20)) - 10);
         default: return $urandom;
      endcase
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
      return 0;
   endfunction

   task automatic send(alu_txn_type t);
      req.valid          <= 1'b1;
      req.opcode         <= t.opcode;
      req.a_lane0        <= t.a[0];
      req.a_lane1        <= t.a[1];
      req.a_lane2        <= t.a[2];
      req.a_lane3        <= t.a[3];
      req.b_lane0        <= t.b[0];
      req.b_lane1        <= t.b[1];
      req.b_lane2        <= t.b[2];
      req.b_lane3        <= t.b[3];
      req.scalar_operand <= t.scalar_operand;
      req.lane_index     <= t.lane_index;
      do @(posedge clock); while (!req.ready);
      sb.note_request(t);
   endtask

   task automatic send_gapped(alu_txn_type t, int gap);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      send(t);
   endtask

   function automatic alu_txn_type random_txn(bit any_op);
      alu_txn_type t;
      t.opcode = any_op ? opcode_type'($urandom_range(0, 15))
                        : opcode_type'($urandom_range(0, 11));
      for (int i = 0; i < 4; i++) begin
         t.a[i] = pick_word();
         t.b[i] = pick_word();
      end
      t.scalar_operand = pick_word();
      t.lane_index     = 2'($urandom_range(0, 3));
      return t;
   endfunction

   task automatic run_stimulus();
      alu_txn_type t;
      for (int k = 0; k < 25; k++) begin
         t = random_txn(0);
         t.opcode = opcode_type'(k % 16);
         t.lane_index = k[1:0];
         if (k < 16) begin
            for (int i = 0; i < 4; i++) begin
               t.a[i] = (k % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
               t.b[i] = (i == 0) ? 32'h0 : ((i == 1) ? 32'hffff_ffff : 32'h8000_0000);
            end
            t.scalar_operand = (k % 3) ? 32'h8000_0000 : 32'hffff_ffff;
         end
         if (k == 16) begin
            t.opcode = OP_DIV;
            t.a = '{32'h8000_0000, 32'h8000_0000, -32'sd7, 32'sd7};
            t.b = '{32'hffff_ffff, 32'h0, 32'sd2, -32'sd2};
         end
         send(t);
      end
      for (int k = 0; k < 1600; k++) begin
         if (k == 800) begin
            req.valid <= 1'b0;
            while (sb.pending_results.size() != 0) @(posedge clock);
         end
         send_gapped(random_txn(k % 10 == 0), (k > 300 && k < 500) ? 0 : gap_len());
      end
      req.valid <= 1'b0;
   endtask

   initial begin
      sb = new();
      reset       = 1'b1;
      req.valid   <= 1'b0;
      req.opcode  <= OP_ADD;
      req.a_lane0 <= '0; req.a_lane1 <= '0; req.a_lane2 <= '0; req.a_lane3 <= '0;
      req.b_lane0 <= '0; req.b_lane1 <= '0; req.b_lane2 <= '0; req.b_lane3 <= '0;
      req.scalar_operand <= '0;
      req.lane_index     <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_stimulus();
      sender_done = 1;
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      hold_rsp = 0;
      wait (!reset);
      repeat (400) @(posedge clock);
      hold_rsp = 1;
      repeat (300) @(posedge clock);
      hold_rsp = 0;
   end

   initial begin
      int stall;
      rsp.ready <= 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp.ready <= 1'b0;
         end else if (hold_rsp) begin
            rsp.ready <= 1'b0;
         end else if (cycle_count > 3000 && cycle_count < 4500) begin
            rsp.ready <= 1'b1;
         end else begin
            stall = gap_len();
            rsp.ready <= (stall == 0);
         end
      end
   end

   always @(posedge clock) begin
      alu_res_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.r[0] = rsp.r_lane0;
         got.r[1] = rsp.r_lane1;
         got.r[2] = rsp.r_lane2;
         got.r[3] = rsp.r_lane3;
         got.scalar_result = rsp.scalar_result;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      wait (sender_done);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

@@ sim.f @@
design/ivalu_pkg.sv
design/ivalu_if.sv
design/ivalu_lane.sv
design/ivalu_merge.sv
design/int32_vector_alu.sv
tb/ivalu_tb_if.sv
tb/tb_int32_vector_alu.sv
